[hw/rtl/kms_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package kms_pkg;

  localparam int ROWS     = 3;
  localparam int COLS     = 3;
  localparam int NUM_KEYS = ROWS * COLS;

  // fixed field widths of the stream words
  localparam int COL_IN_W    = 3;
  localparam int THR_W       = 8;
  localparam int ROW_DRIVE_W = 3;
  localparam int KEY_CODE_W  = 4;
  localparam int S_TDATA_W   = 8;
  localparam int M_TDATA_W   = 8;

  localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int KEY_W = $clog2(NUM_KEYS + 1);
  localparam int PAD_W = (COLS > COL_IN_W) ? COLS : COL_IN_W;

  typedef logic [ROW_W-1:0]    row_idx_t;
  typedef logic [NUM_KEYS-1:0] key_vec_t;
  typedef logic [THR_W-1:0]    count_t;

  // one scan tick as seen by the debounce bank
  typedef struct packed {
    logic     update;    // tick that completes a full scan
    key_vec_t raw_keys;  // row-major raw key levels
  } scan_tick_t;

endpackage

`default_nettype wire

[hw/rtl/kms_scan.sv]
`timescale 1ns / 1ps
`default_nettype none

module kms_scan (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                tick,
  input  wire logic [kms_pkg::COL_IN_W-1:0]        column_levels,
  output kms_pkg::scan_tick_t                      scan_tick,
  output logic      [kms_pkg::ROW_DRIVE_W-1:0]     row_drive
);

  kms_pkg::row_idx_t             scan_row;
  kms_pkg::row_idx_t             scan_row_next;
  logic [kms_pkg::COLS-1:0]      raw_rows [kms_pkg::ROWS];
  logic [kms_pkg::PAD_W-1:0]     cols_pad;
  logic [kms_pkg::COLS-1:0]      cols_in;
  logic                          last_row;
  logic [kms_pkg::ROWS-1:0]      drive_onehot;

  assign cols_pad = kms_pkg::PAD_W'(column_levels);
  assign cols_in  = cols_pad[kms_pkg::COLS-1:0];
  assign last_row = (scan_row == kms_pkg::ROW_W'(kms_pkg::ROWS - 1));

  assign scan_row_next = last_row ? '0 : scan_row + kms_pkg::ROW_W'(1);

  assign drive_onehot = kms_pkg::ROWS'(1) << scan_row_next;
  assign row_drive    = kms_pkg::ROW_DRIVE_W'(drive_onehot);

  // the last row comes straight from the input word, the others from storage
  always_comb begin
    scan_tick.update = tick && last_row;
    for (int r = 0; r < kms_pkg::ROWS; r++) begin
      for (int c = 0; c < kms_pkg::COLS; c++) begin
        if (r == kms_pkg::ROWS - 1) begin
          scan_tick.raw_keys[r*kms_pkg::COLS + c] = cols_in[c];
        end else begin
          scan_tick.raw_keys[r*kms_pkg::COLS + c] = raw_rows[r][c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_row <= '0;
    end else if (tick) begin
      scan_row <= scan_row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      raw_rows[scan_row] <= cols_in;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    scan_row <= kms_pkg::ROW_W'(kms_pkg::ROWS - 1))
    else $error("scan row out of range");

endmodule

`default_nettype wire

[hw/rtl/kms_debounce.sv]
`timescale 1ns / 1ps
`default_nettype none

module kms_debounce (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire kms_pkg::scan_tick_t scan_tick,
  input  wire kms_pkg::count_t     key_threshold,
  output kms_pkg::key_vec_t        keys_next
);

  kms_pkg::count_t   counts      [kms_pkg::NUM_KEYS];
  kms_pkg::count_t   counts_next [kms_pkg::NUM_KEYS];
  kms_pkg::key_vec_t keys;

  // integrating counter per key; level flips only at the rails
  always_comb begin
    keys_next = keys;
    for (int k = 0; k < kms_pkg::NUM_KEYS; k++) begin
      counts_next[k] = counts[k];
      if (scan_tick.update) begin
        if (scan_tick.raw_keys[k]) begin
          if (counts[k] < key_threshold) begin
            counts_next[k] = counts[k] + kms_pkg::THR_W'(1);
          end else begin
            keys_next[k] = 1'b1;
          end
        end else begin
          if (counts[k] != '0) begin
            counts_next[k] = counts[k] - kms_pkg::THR_W'(1);
          end else begin
            keys_next[k] = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      keys <= '0;
      for (int k = 0; k < kms_pkg::NUM_KEYS; k++) begin
        counts[k] <= '0;
      end
    end else begin
      keys <= keys_next;
      for (int k = 0; k < kms_pkg::NUM_KEYS; k++) begin
        counts[k] <= counts_next[k];
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    !scan_tick.update |=> keys == $past(keys))
    else $error("debounced level changed outside a full-scan tick");

endmodule

`default_nettype wire

[hw/rtl/kms_encode.sv]
`timescale 1ns / 1ps
`default_nettype none

module kms_encode (
  input  wire kms_pkg::key_vec_t               keys,
  output logic [kms_pkg::KEY_CODE_W-1:0]       key_code
);

  logic [kms_pkg::KEY_W-1:0] code;

  // scan downward so the lowest key index wins
  always_comb begin
    code = '0;
    for (int k = kms_pkg::NUM_KEYS - 1; k >= 0; k--) begin
      if (keys[k]) begin
        code = kms_pkg::KEY_W'(k + 1);
      end
    end
  end

  assign key_code = kms_pkg::KEY_CODE_W'(code);

endmodule

`default_nettype wire

[hw/rtl/keypad_matrix_scan_debounce.sv]
`timescale 1ns / 1ps
`default_nettype none

// 3x3 keypad scanner with integrating debounce. Each input word is one scan
// tick carrying the column levels sampled for the row currently driven; the
// block answers every word with one output word holding the one-hot row to
// drive next and the code of the first debounced key in row-major order
// (row*3+col+1, 0 when no key is down). Debounce counters for all nine keys
// step together on the tick that samples the last row, so key_threshold
// counts full scans. One word per cycle: the state update and the result
// register share a single clock edge, and a full output register stalls the
// input only while the downstream side is not taking. key_threshold is
// written through the cfg channel, which is always ready.
module keypad_matrix_scan_debounce (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire logic [kms_pkg::S_TDATA_W-1:0]    s_axis_tdata,  // [2:0] column_levels
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  output logic      [kms_pkg::M_TDATA_W-1:0]    m_axis_tdata,  // [2:0] row_drive, [6:3] key_code
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [kms_pkg::THR_W-1:0]        cfg_data
);

  logic                                 tick;
  kms_pkg::scan_tick_t                  scan_tick;
  logic [kms_pkg::ROW_DRIVE_W-1:0]      row_drive;
  logic [kms_pkg::KEY_CODE_W-1:0]       key_code;
  kms_pkg::key_vec_t                    keys_next;
  kms_pkg::count_t                      key_threshold;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign tick          = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      key_threshold <= cfg_data;
    end
  end

  kms_scan u_scan (
    .clk           (clk),
    .rst           (rst),
    .tick          (tick),
    .column_levels (s_axis_tdata[kms_pkg::COL_IN_W-1:0]),
    .scan_tick     (scan_tick),
    .row_drive     (row_drive)
  );

  kms_debounce u_debounce (
    .clk           (clk),
    .rst           (rst),
    .scan_tick     (scan_tick),
    .key_threshold (key_threshold),
    .keys_next     (keys_next)
  );

  kms_encode u_encode (
    .keys     (keys_next),
    .key_code (key_code)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (tick) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick) begin
      m_axis_tdata <= kms_pkg::M_TDATA_W'({key_code, row_drive});
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    tick |=> m_axis_tvalid)
    else $error("accepted word produced no result");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> $onehot(m_axis_tdata[kms_pkg::ROW_DRIVE_W-1:0]))
    else $error("row drive not one-hot");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tdata[kms_pkg::ROW_DRIVE_W +: kms_pkg::KEY_CODE_W] <=
       kms_pkg::KEY_CODE_W'(kms_pkg::NUM_KEYS)))
    else $error("key code out of range");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while result is stalled");

endmodule

`default_nettype wire

[bench/tb_keypad_matrix_scan_debounce.sv]
`timescale 1ns / 1ps

module tb_keypad_matrix_scan_debounce;

  typedef struct packed {
    logic [kms_pkg::KEY_CODE_W-1:0]  key_code;
    logic [kms_pkg::ROW_DRIVE_W-1:0] row_drive;
  } scan_result_t;

  typedef struct {
    logic [kms_pkg::COL_IN_W-1:0] cols;
    bit                           typed;
    scan_result_t                 want;
  } tick_row_t;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 80;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_axis_tvalid = 1'b0;
  logic                          s_axis_tready;
  logic [kms_pkg::S_TDATA_W-1:0] s_axis_tdata = '0;  // [2:0] column_levels
  logic                          m_axis_tvalid;
  logic                          m_axis_tready = 1'b0;
  logic [kms_pkg::M_TDATA_W-1:0] m_axis_tdata;       // [2:0] row_drive, [6:3] key_code
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [kms_pkg::THR_W-1:0]     cfg_data = '0;

  keypad_matrix_scan_debounce uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // scanner shadow state
  logic [kms_pkg::COL_IN_W-1:0] raw_shadow [kms_pkg::ROWS];
  kms_pkg::count_t              count_shadow [kms_pkg::NUM_KEYS];
  kms_pkg::key_vec_t            down_shadow = '0;
  kms_pkg::count_t              thr_shadow = '0;
  int unsigned                  row_shadow = 0;

  scan_result_t scans_due [$];
  int           mismatches = 0;
  bit           s_rush = 1'b0;
  bit           hold_req = 1'b0;

  // threshold 0 after reset: keys follow the raw scan as each full scan completes
  tick_row_t tick_rows [24] = '{
    '{3'b111, 1'b1, '{4'd0, 3'b010}},
    '{3'b000, 1'b1, '{4'd0, 3'b100}},
    '{3'b000, 1'b1, '{4'd1, 3'b001}},
    '{3'b000, 1'b1, '{4'd1, 3'b010}},
    '{3'b000, 1'b1, '{4'd1, 3'b100}},
    '{3'b100, 1'b1, '{4'd9, 3'b001}},
    '{3'b000, 1'b1, '{4'd9, 3'b010}},
    '{3'b000, 1'b1, '{4'd9, 3'b100}},
    '{3'b000, 1'b1, '{4'd0, 3'b001}},
    '{3'b010, 1'b1, '{4'd0, 3'b010}},
    '{3'b001, 1'b1, '{4'd0, 3'b100}},
    '{3'b000, 1'b1, '{4'd2, 3'b001}},
    '{3'b000, 1'b1, '{4'd2, 3'b010}},
    '{3'b101, 1'b1, '{4'd2, 3'b100}},
    '{3'b010, 1'b1, '{4'd4, 3'b001}},
    '{3'b000, 1'b1, '{4'd4, 3'b010}},
    '{3'b000, 1'b1, '{4'd4, 3'b100}},
    '{3'b000, 1'b1, '{4'd0, 3'b001}},
    '{3'b111, 1'b0, '{4'd0, 3'b000}},
    '{3'b111, 1'b0, '{4'd0, 3'b000}},
    '{3'b111, 1'b0, '{4'd0, 3'b000}},
    '{3'b000, 1'b1, '{4'd1, 3'b010}},
    '{3'b000, 1'b1, '{4'd1, 3'b100}},
    '{3'b000, 1'b1, '{4'd0, 3'b001}}
  };

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (mismatches < 50)
      $display("%0t ns: %s got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // one scan tick through the shadow scanner
  function automatic scan_result_t scan_tick(input logic [kms_pkg::COL_IN_W-1:0] cols);
    scan_result_t res;
    int           r;
    int           c;
    int           k;
    raw_shadow[row_shadow] = cols;
    if (row_shadow == kms_pkg::ROWS - 1) begin
      for (r = 0; r < kms_pkg::ROWS; r++) begin
        for (c = 0; c < kms_pkg::COLS; c++) begin
          k = r * kms_pkg::COLS + c;
          if (raw_shadow[r][c]) begin
            // a count above a lowered threshold stays put
            if (count_shadow[k] < thr_shadow) count_shadow[k]++;
            else down_shadow[k] = 1'b1;
          end else if (count_shadow[k] != 0) begin
            count_shadow[k]--;
          end else begin
            down_shadow[k] = 1'b0;
          end
        end
      end
    end
    row_shadow = (row_shadow + 1) % kms_pkg::ROWS;
    res.row_drive = kms_pkg::ROW_DRIVE_W'(1 << row_shadow);
    res.key_code  = '0;
    for (k = kms_pkg::NUM_KEYS - 1; k >= 0; k--)
      if (down_shadow[k]) res.key_code = kms_pkg::KEY_CODE_W'(k + 1);
    return res;
  endfunction

  function automatic int pick_gap(input bit rush);
    if (rush) return 0;
    return $urandom_range(0, 16);
  endfunction

  // called at a clock edge; returns at the edge the word is taken
  task automatic send_word(input logic [kms_pkg::COL_IN_W-1:0] cols, input bit typed,
                           input scan_result_t want);
    scan_result_t res;
    int           gap;
    res = scan_tick(cols);
    scans_due.push_back(typed ? want : res);
    gap = pick_gap(s_rush);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(kms_pkg::S_TDATA_W - kms_pkg::COL_IN_W){1'b0}}, cols};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic write_threshold(input kms_pkg::count_t thr);
    cfg_valid <= 1'b1;
    cfg_data  <= thr;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    thr_shadow = thr;
  endtask

  task automatic finish_phase();
    s_axis_tvalid <= 1'b0;
    while (scans_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic kms_pkg::key_vec_t make_pattern();
    kms_pkg::key_vec_t p;
    p = '0;
    case ($urandom_range(0, 3))
      0: p = '0;
      1: p[$urandom_range(0, kms_pkg::NUM_KEYS - 1)] = 1'b1;
      2: begin
        p[$urandom_range(0, kms_pkg::NUM_KEYS - 1)] = 1'b1;
        p[$urandom_range(0, kms_pkg::NUM_KEYS - 1)] = 1'b1;
      end
      default: p = kms_pkg::key_vec_t'($urandom);
    endcase
    return p;
  endfunction

  // held key patterns over many scans, with bounce and junk words mixed in;
  // churn is the odds (1 in churn scans) of a new pattern, 0 holds it all phase
  task automatic run_phase(input kms_pkg::count_t thr, input int words, input int churn,
                           input bit squeeze);
    kms_pkg::key_vec_t            pattern;
    logic [kms_pkg::COL_IN_W-1:0] cols;
    int                           i;
    write_threshold(thr);
    pattern = make_pattern();
    if (churn == 0) pattern[$urandom_range(0, kms_pkg::NUM_KEYS - 1)] = 1'b1;
    if (squeeze) begin
      s_rush   = 1'b1;
      hold_req = 1'b1;
    end
    for (i = 0; i < words; i++) begin
      if (!squeeze && i % 32 == 0) s_rush = ($urandom_range(0, 3) == 0);
      if (row_shadow == 0 && churn != 0 && $urandom_range(1, churn) == 1)
        pattern = make_pattern();
      cols = pattern[row_shadow * kms_pkg::COLS +: kms_pkg::COLS];
      case ($urandom_range(0, 11))
        0: cols = kms_pkg::COL_IN_W'($urandom_range(0, 7));
        1: cols[$urandom_range(0, kms_pkg::COLS - 1)] ^= 1'b1;
        default: ;
      endcase
      send_word(cols, 1'b0, '0);
    end
    finish_phase();
  endtask

  initial begin
    foreach (raw_shadow[i]) raw_shadow[i] = '0;
    foreach (count_shadow[i]) count_shadow[i] = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_threshold(8'd0);
    foreach (tick_rows[i]) send_word(tick_rows[i].cols, tick_rows[i].typed, tick_rows[i].want);
    finish_phase();
    run_phase(8'd1, 120, 4, 1'b0);
    run_phase(8'd3, 120, 6, 1'b1);
    s_rush = 1'b0;
    run_phase(8'd255, 150, 0, 1'b0);
    // counts of the held keys now sit far above the new threshold
    run_phase(8'd7, 90, 12, 1'b0);
    run_phase(kms_pkg::count_t'($urandom_range(0, 15)), 120, 5, 1'b0);
    run_phase(8'd0, 100, 3, 1'b0);
    repeat (8) @(posedge clk);
    if (scans_due.size() != 0) flag_mismatch("words never returned", 0, scans_due.size());
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // downstream side: random stalls, rush stretches, one long hold on request
  initial begin
    int gap;
    int taken;
    bit r_rush;
    taken  = 0;
    r_rush = 1'b0;
    forever begin
      if (taken % 32 == 0) r_rush = ($urandom_range(0, 3) == 0);
      gap = pick_gap(r_rush);
      if (hold_req) begin
        gap      = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      taken++;
    end
  end

  always @(posedge clk) begin
    scan_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (scans_due.size() == 0) begin
        flag_mismatch("unexpected word, tdata", m_axis_tdata, 0);
      end else begin
        want = scans_due.pop_front();
        if (m_axis_tdata[2:0] !== want.row_drive)
          flag_mismatch("row_drive", m_axis_tdata[2:0], want.row_drive);
        if (m_axis_tdata[6:3] !== want.key_code)
          flag_mismatch("key_code", m_axis_tdata[6:3], want.key_code);
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

[filelist.f]
hw/rtl/kms_pkg.sv
hw/rtl/kms_scan.sv
hw/rtl/kms_debounce.sv
hw/rtl/kms_encode.sv
hw/rtl/keypad_matrix_scan_debounce.sv
bench/tb_keypad_matrix_scan_debounce.sv
